FILE: sv/cdeq_pkg.sv
// shared types and constants for the circular double-ended queue
// no dependencies; imported by every module of the block
package cdeq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CAP_W = 5;
	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_POP_FRONT  = 2'd1,
		OP_PUSH_FRONT = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef struct packed {
		op_t   operation;
		data_t push_value;
	} in_t;

	typedef struct packed {
		data_t   pop_value;
		status_t status;
		logic    now_empty;
		logic    now_full;
	} out_t;

	// per-cell control: shift towards the back, shift towards the front, load
	typedef struct packed {
		logic shr;
		logic shl;
		logic ld;
	} cell_ctl_t;

endpackage

FILE: sv/circular_double_ended_queue.sv
// top level of the circular double-ended queue: row of word cells, fill count, result register
// depends on cdeq_pkg and cdeq_cell
// the result word of an accepted operation is registered in the result register
// throughput: one operation per cycle, held off while the result word waits on out_ready
// the front of the queue always sits in cell 0; the fill count marks the back
// reset: queue empty, capacity 16, no result pending; cell contents are not reset
module circular_double_ended_queue
	import cdeq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_t             out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data
);

	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic [CNT_W-1:0] cap_eff;
	logic [CNT_W-1:0] back_pos;
	logic             out_valid_q;
	out_t             out_data_q;
	out_t             result;
	logic             accept;
	logic             full;
	logic             empty;
	logic             go_push_back;
	logic             go_push_front;
	logic             go_pop_front;
	data_t            cell_val [DEPTH];

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	// zero is treated as one, anything past the row length as the row length
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (32'(cap_q) > 32'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
	end

	assign full     = (count_q == cap_eff);
	assign empty    = (count_q == '0);
	assign back_pos = count_q - CNT_W'(1);

	always_comb begin
		go_push_back  = 1'b0;
		go_push_front = 1'b0;
		go_pop_front  = 1'b0;
		count_nxt     = count_q;
		result        = '{pop_value: '0, status: ST_OK, now_empty: 1'b0, now_full: 1'b0};
		unique case (in_data.operation)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (full) begin
					result.status = ST_OVERFLOW;
				end else begin
					go_push_back  = (in_data.operation == OP_PUSH_BACK);
					go_push_front = (in_data.operation == OP_PUSH_FRONT);
					count_nxt     = count_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					result.status = ST_UNDERFLOW;
				end else begin
					go_pop_front     = 1'b1;
					result.pop_value = cell_val[0];
					count_nxt        = back_pos;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					result.status = ST_UNDERFLOW;
				end else begin
					result.pop_value = cell_val[back_pos[IDX_W-1:0]];
					count_nxt        = back_pos;
				end
			end
			default: begin
				result.status = ST_OK;
			end
		endcase
		result.now_empty = (count_nxt == '0);
		result.now_full  = (count_nxt == cap_eff);
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			cell_ctl_t ctl;
			data_t     left;
			data_t     right;

			assign ctl.shr = accept && go_push_front;
			assign ctl.shl = accept && go_pop_front;
			assign ctl.ld  = accept && go_push_back && (count_q == CNT_W'(gi));

			if (gi == 0) begin : g_head
				assign left = in_data.push_value;
			end else begin : g_mid_l
				assign left = cell_val[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_tail
				assign right = in_data.push_value;
			end else begin : g_mid_r
				assign right = cell_val[gi+1];
			end

			cdeq_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.push_value (in_data.push_value),
				.left       (left),
				.right      (right),
				.value      (cell_val[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				// a new capacity drops whatever the queue held
				cap_q   <= cfg_data;
				count_q <= '0;
			end else if (accept) begin
				count_q <= count_nxt;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: sv/cdeq_cell.sv
// one storage cell of the queue row, holding a single word
// depends on cdeq_pkg
module cdeq_cell
	import cdeq_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  data_t     push_value,
	input  data_t     left,
	input  data_t     right,
	output data_t     value
);

	data_t value_q;

	always_ff @(posedge clk) begin
		if (ctl.ld) begin
			value_q <= push_value;
		end else if (ctl.shr) begin
			value_q <= left;
		end else if (ctl.shl) begin
			value_q <= right;
		end
	end

	assign value = value_q;

endmodule

FILE: sv/cdeq_checker.sv
// port-level checks for the circular double-ended queue, bound to the top level
// depends on cdeq_pkg
module cdeq_props
	import cdeq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	a_underflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_UNDERFLOW |-> out_data.pop_value == '0)
		else $error("underflow word carries a value");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_UNDERFLOW |-> out_data.now_empty)
		else $error("underflow reported on a queue that is not empty");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_OVERFLOW |-> out_data.now_full)
		else $error("overflow reported on a queue that is not full");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.now_empty && out_data.now_full))
		else $error("queue reported empty and full at once");

endmodule

bind circular_double_ended_queue cdeq_props u_cdeq_props (.*);

FILE: sim/cdeq_checker.sv
// watches the operation, result and capacity channels of the double-ended queue
// keeps its own deque and capacity, predicts each result word and compares it
// depends on cdeq_pkg
module cdeq_checker
	import cdeq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  in_t              in_data,
	input  logic             out_valid,
	input  logic             out_ready,
	input  out_t             out_data,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [CAP_W-1:0] cfg_data,
	output int               fail_count,
	output int               words_due
);
	timeunit 1ns;
	timeprecision 1ps;

	data_t deque_model[$];
	out_t  result_words[$];
	int    capacity;

	initial begin
		fail_count = 0;
		words_due = 0;
		capacity = DEPTH;
	end

	function automatic int clamp_capacity(input logic [CAP_W-1:0] c);
		if (c == '0) begin
			return 1;
		end
		if (int'(c) > DEPTH) begin
			return DEPTH;
		end
		return int'(c);
	endfunction

	// one operation on the model deque, giving the result word it should produce
	function automatic out_t deque_step(input in_t item);
		out_t r;
		r.pop_value = '0;
		r.status = ST_OK;
		case (item.operation)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (deque_model.size() >= capacity) begin
					r.status = ST_OVERFLOW;
				end else if (item.operation == OP_PUSH_BACK) begin
					deque_model.push_back(item.push_value);
				end else begin
					deque_model.push_front(item.push_value);
				end
			end
			default: begin
				if (deque_model.size() == 0) begin
					r.status = ST_UNDERFLOW;
				end else if (item.operation == OP_POP_FRONT) begin
					r.pop_value = deque_model.pop_front();
				end else begin
					r.pop_value = deque_model.pop_back();
				end
			end
		endcase
		r.now_empty = (deque_model.size() == 0);
		r.now_full = (deque_model.size() == capacity);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			deque_model.delete();
			result_words.delete();
			capacity = clamp_capacity(CAP_RESET);
			words_due = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (result_words.size() == 0) begin
					report_mismatch("unexpected word", out_data.pop_value, '0);
				end else begin
					want = result_words.pop_front();
					if (out_data.pop_value !== want.pop_value)
						report_mismatch("pop_value", out_data.pop_value, want.pop_value);
					if (out_data.status !== want.status)
						report_mismatch("status", 32'(out_data.status), 32'(want.status));
					if (out_data.now_empty !== want.now_empty)
						report_mismatch("now_empty", 32'(out_data.now_empty),
							32'(want.now_empty));
					if (out_data.now_full !== want.now_full)
						report_mismatch("now_full", 32'(out_data.now_full),
							32'(want.now_full));
				end
			end
			// a capacity write drops whatever the queue held
			if (cfg_valid && cfg_ready) begin
				capacity = clamp_capacity(cfg_data);
				deque_model.delete();
			end
			if (in_valid && in_ready) begin
				result_words.push_back(deque_step(in_data));
			end
			words_due = result_words.size();
		end
	end

endmodule

FILE: sim/circular_double_ended_queue_tb.sv
// top of the double-ended queue testbench: clock, reset, stimulus, stalls and verdict
// depends on cdeq_pkg, cdeq_checker and the circular_double_ended_queue block
module circular_double_ended_queue_tb;
	import cdeq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 80;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_t              in_data;
	logic             out_valid;
	logic             out_ready;
	out_t             out_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data;

	int fail_count;
	int words_due;
	int send_idle_pct = 29;
	int recv_idle_pct = 52;
	int hold_requests = 0;
	int quiet_cycles = 0;
	int burst_left = 0;
	int push_pct = 50;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	circular_double_ended_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	cdeq_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.words_due  (words_due)
	);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
			|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_OFF_CYCLES - 1;
				out_ready = 1'b0;
			end else begin
				out_ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	function automatic data_t pick_value();
		case ($urandom_range(7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return '1;
			default: return data_t'($urandom);
		endcase
	endfunction

	function automatic logic [CAP_W-1:0] capacity_plan(input int n);
		case (n)
			0: return CAP_W'(1);
			1: return CAP_W'(16);
			2: return CAP_W'(0);
			3: return CAP_W'(31);
			4: return CAP_W'(3);
			5: return CAP_W'($urandom_range(1, 16));
			6: return CAP_W'(2);
			7: return CAP_W'(17);
			8: return CAP_W'(16);
			9: return CAP_W'(1);
			10: return CAP_W'($urandom_range(0, 31));
			default: return CAP_W'(8);
		endcase
	endfunction

	task automatic send_op(input op_t op, input data_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data.operation = op;
		in_data.push_value = v;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// runs of push-heavy, balanced and pop-heavy words so the queue swings between full and empty
	task automatic send_random();
		op_t op;
		if (burst_left == 0) begin
			case ($urandom_range(2))
				0: push_pct = 15;
				1: push_pct = 50;
				default: push_pct = 85;
			endcase
			burst_left = $urandom_range(3, 40);
		end
		burst_left--;
		if ($urandom_range(99) < push_pct) begin
			if ($urandom_range(1) != 0) begin
				op = OP_PUSH_BACK;
			end else begin
				op = OP_PUSH_FRONT;
			end
		end else begin
			if ($urandom_range(1) != 0) begin
				op = OP_POP_FRONT;
			end else begin
				op = OP_POP_BACK;
			end
		end
		send_op(op, pick_value());
	endtask

	task automatic set_capacity(input logic [CAP_W-1:0] c);
		while (words_due != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = c;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// underflow on both ends, pushes onto an empty queue, extremes of the data
		send_op(OP_POP_FRONT, '0);
		send_op(OP_POP_BACK, '1);
		send_op(OP_PUSH_BACK, 32'sh7fff_ffff);
		send_op(OP_PUSH_FRONT, 32'sh8000_0000);
		send_op(OP_PUSH_BACK, '0);
		send_op(OP_PUSH_FRONT, '1);
		send_op(OP_POP_FRONT, '0);
		send_op(OP_POP_BACK, '0);
		send_op(OP_POP_FRONT, '0);
		send_op(OP_POP_BACK, '0);
		send_op(OP_PUSH_FRONT, 32'sh0000_0005);
		send_op(OP_PUSH_BACK, 32'sh0000_0006);
		// capacity write with words still queued drops them
		set_capacity(CAP_W'(1));
		send_op(OP_POP_FRONT, '0);
		send_op(OP_PUSH_FRONT, 32'sh5a5a_a5a5);
		send_op(OP_PUSH_BACK, 32'sh1234_5678);
		send_op(OP_POP_BACK, '0);
		send_op(OP_PUSH_BACK, 32'sh7654_3210);
		send_op(OP_PUSH_FRONT, 32'sh0f0f_0f0f);
		send_op(OP_POP_FRONT, '0);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 52 : 0;
			recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 29 : 0;
			for (int seg = 0; seg < 4; seg++) begin
				set_capacity(capacity_plan(ph * 4 + seg));
				if (ph == 2 && seg == 1) begin
					hold_requests++;
				end
				repeat (50) send_random();
			end
		end

		while (words_due != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
